/* src/tcgr_pkg.sv */
// Shared types and constants of the text console glyph renderer.
`default_nettype none
package tcgr_pkg;

  localparam int unsigned GLYPH_ROWS     = 8;
  localparam int unsigned ROW_BITS       = $clog2(GLYPH_ROWS);
  localparam int unsigned COORD_BITS     = 12;
  localparam int unsigned DIM_BITS       = 12;
  localparam int unsigned CODE_BITS      = 7;
  localparam int unsigned PAT_BITS       = 8;
  localparam int unsigned DIGIT_BITS     = 4;
  localparam int unsigned CFG_IDX_BITS   = 2;
  localparam int unsigned FONT_CHARS_DEF = 128;

  localparam logic [DIM_BITS-1:0]   WIDTH_RESET  = 12'd640;
  localparam logic [DIM_BITS-1:0]   HEIGHT_RESET = 12'd480;
  localparam logic [CODE_BITS-1:0]  CHAR_NEWLINE = 7'd10;
  localparam logic [CODE_BITS-1:0]  ASCII_ZERO   = 7'd48;
  localparam logic [CODE_BITS-1:0]  ASCII_HEX_A  = 7'd55;
  localparam logic [DIGIT_BITS-1:0] DIGIT_MAX    = 4'd9;

  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd1;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_CHAR  = 2'd1,
    MODE_HEX   = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef struct packed {
    logic                  clr;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  last;
  } meta_t;

endpackage
`default_nettype wire

/* src/text_console_glyph_renderer_core.sv */
// Top level of the text console glyph renderer: font memory, cursor and row sequencer.
//
// Channel  Dir  Words carried
// s_axis   in   tuser mode; tdata char_code, glyph_row, row_pattern, hex_digit
// m_axis   out  tuser clear_screen; tlast last; tdata pixel_x, pixel_y, paint_mask
// cfg      in   register index and 12-bit value, always ready
//
// A font load gives no word. A clear or a newline past the bottom edge gives one
// word. A glyph gives eight words, nine with a clear in front, one per cycle while
// the output is not stalled, from the single read port of the font memory.
// The next input word is taken in the cycle the last word of an item is issued.
// Reset homes the cursor and returns the screen registers to 640 by 480; the font
// memory is not cleared.
// A stalled output holds the sequencer and the memory read register once the p1 stage holds a word.
`default_nettype none
module text_console_glyph_renderer_core #(
  parameter int unsigned FONT_CHARS = tcgr_pkg::FONT_CHARS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [23:0]                        s_axis_tdata,  // char_code, glyph_row,
                                                                 // row_pattern, hex_digit
  input  wire logic [1:0]                         s_axis_tuser,  // mode
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [31:0]                             m_axis_tdata,  // pixel_x, pixel_y,
                                                                 // paint_mask
  output logic [0:0]                              m_axis_tuser,  // clear_screen
  output logic                                    m_axis_tlast,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [tcgr_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  wire logic [tcgr_pkg::DIM_BITS-1:0]      cfg_data_i
);
  import tcgr_pkg::*;

  localparam int unsigned IDX_BITS   = $clog2(FONT_CHARS);
  localparam int unsigned ADDR_BITS  = IDX_BITS + ROW_BITS;
  localparam int unsigned MEM_DEPTH  = FONT_CHARS * GLYPH_ROWS;
  localparam logic [ROW_BITS-1:0] ROW_LAST = ROW_BITS'(GLYPH_ROWS - 1);
  localparam logic [COORD_BITS:0] STEP     = (COORD_BITS+1)'(GLYPH_ROWS);

  logic [PAT_BITS-1:0] font_mem [MEM_DEPTH];
  logic [PAT_BITS-1:0] rdata_q;

  logic [DIM_BITS-1:0]   width_q, height_q;
  logic [COORD_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;

  logic                  seq_busy_q, seq_busy_d;
  logic                  seq_clr_q, seq_clr_d;
  logic                  seq_draw_q, seq_draw_d;
  logic [ROW_BITS-1:0]   seq_row_q, seq_row_d;
  logic [IDX_BITS-1:0]   seq_idx_q, seq_idx_d;
  logic [COORD_BITS-1:0] seq_x_q, seq_x_d, seq_y_q, seq_y_d;

  logic  p1_valid_q;
  meta_t p1_meta_q, p1_meta_d;
  logic  out_valid_q;
  meta_t out_meta_q;
  logic [PAT_BITS-1:0] out_mask_q;

  mode_e                 in_mode;
  logic [CODE_BITS-1:0]  in_code, draw_code;
  logic [ROW_BITS-1:0]   in_row;
  logic [PAT_BITS-1:0]   in_pat;
  logic [DIGIT_BITS-1:0] in_digit;
  logic                  in_acc, out_free, adv, issue, seq_final;
  logic                  mem_we;
  logic [ADDR_BITS-1:0]  wr_addr, rd_addr;
  logic                  start, start_clr, start_draw;
  logic [IDX_BITS-1:0]   start_idx;
  logic [COORD_BITS-1:0] nl_y, wrap_y, draw_x, draw_y;
  logic                  wrap, bottom;

  // Glyph index of a character code, reduced by compare and subtract steps.
  function automatic logic [IDX_BITS-1:0] font_index(input logic [CODE_BITS-1:0] code);
    logic [CODE_BITS-1:0] rem;
    rem = code;
    for (int s = CODE_BITS - 1; s >= 0; s--) begin
      if ((FONT_CHARS << s) < (1 << CODE_BITS)) begin
        if (32'(rem) >= (FONT_CHARS << s)) begin
          rem = rem - CODE_BITS'(FONT_CHARS << s);
        end
      end
    end
    return IDX_BITS'(rem);
  endfunction

  assign in_mode  = mode_e'(s_axis_tuser);
  assign in_code  = s_axis_tdata[6:0];
  assign in_row   = s_axis_tdata[9:7];
  assign in_pat   = s_axis_tdata[17:10];
  assign in_digit = s_axis_tdata[21:18];

  assign cfg_ready_o = 1'b1;

  assign out_free  = !out_valid_q || m_axis_tready;
  assign adv       = !p1_valid_q || out_free;
  assign issue     = seq_busy_q && adv;
  assign seq_final = seq_clr_q ? !seq_draw_q : (seq_row_q == ROW_LAST);
  assign s_axis_tready = !seq_busy_q || (issue && seq_final);
  assign in_acc    = s_axis_tvalid && s_axis_tready;

  assign mem_we  = in_acc && (in_mode == MODE_LOAD);
  assign wr_addr = {font_index(in_code), in_row};
  assign rd_addr = {seq_idx_q, seq_row_q};

  always_comb begin
    draw_code = (in_digit > DIGIT_MAX) ? (CODE_BITS'(in_digit) + ASCII_HEX_A)
                                       : (CODE_BITS'(in_digit) + ASCII_ZERO);
    if (in_mode == MODE_CHAR) begin
      draw_code = in_code;
    end
    start_idx = font_index(draw_code);
    nl_y   = COORD_BITS'({1'b0, cur_y_q} + STEP);
    wrap   = ({1'b0, cur_x_q} + STEP) > (COORD_BITS+1)'(width_q);
    wrap_y = wrap ? nl_y : cur_y_q;
    bottom = ({1'b0, wrap_y} + STEP) > (COORD_BITS+1)'(height_q);
    draw_x = (wrap || bottom) ? '0 : cur_x_q;
    draw_y = bottom ? '0 : wrap_y;
  end

  always_comb begin
    start      = 1'b0;
    start_clr  = 1'b0;
    start_draw = 1'b0;
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    if (in_acc) begin
      case (in_mode)
        MODE_LOAD: begin
        end
        MODE_CLEAR: begin
          start     = 1'b1;
          start_clr = 1'b1;
          cur_x_d   = '0;
          cur_y_d   = '0;
        end
        MODE_CHAR, MODE_HEX: begin
          if ((in_mode == MODE_CHAR) && (in_code == CHAR_NEWLINE)) begin
            cur_x_d = '0;
            if (({1'b0, nl_y} + STEP) > (COORD_BITS+1)'(height_q)) begin
              start     = 1'b1;
              start_clr = 1'b1;
              cur_y_d   = '0;
            end else begin
              cur_y_d = nl_y;
            end
          end else begin
            start      = 1'b1;
            start_clr  = bottom;
            start_draw = 1'b1;
            cur_x_d    = COORD_BITS'({1'b0, draw_x} + STEP);
            cur_y_d    = draw_y;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    seq_busy_d = seq_busy_q;
    seq_clr_d  = seq_clr_q;
    seq_draw_d = seq_draw_q;
    seq_row_d  = seq_row_q;
    seq_idx_d  = seq_idx_q;
    seq_x_d    = seq_x_q;
    seq_y_d    = seq_y_q;
    if (start) begin
      seq_busy_d = 1'b1;
      seq_clr_d  = start_clr;
      seq_draw_d = start_draw;
      seq_row_d  = '0;
      seq_idx_d  = start_idx;
      seq_x_d    = draw_x;
      seq_y_d    = draw_y;
    end else if (issue) begin
      if (seq_final) begin
        seq_busy_d = 1'b0;
      end
      if (seq_clr_q) begin
        seq_clr_d = 1'b0;
      end else begin
        seq_row_d = seq_row_q + 1'b1;
      end
    end
  end

  always_comb begin
    p1_meta_d.clr  = seq_clr_q;
    p1_meta_d.last = seq_final;
    p1_meta_d.x    = seq_clr_q ? '0 : seq_x_q;
    p1_meta_d.y    = seq_clr_q ? '0 : (seq_y_q + COORD_BITS'(seq_row_q));
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      font_mem[wr_addr] <= in_pat;
    end
    if (issue && !seq_clr_q) begin
      rdata_q <= font_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WIDTH_RESET;
      height_q   <= HEIGHT_RESET;
      cur_x_q    <= '0;
      cur_y_q    <= '0;
      seq_busy_q <= 1'b0;
      seq_clr_q  <= 1'b0;
      seq_draw_q <= 1'b0;
      seq_row_q  <= '0;
      p1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_SCREEN_WIDTH) begin
          width_q <= cfg_data_i;
        end else if (cfg_index_i == REG_SCREEN_HEIGHT) begin
          height_q <= cfg_data_i;
        end
      end
      cur_x_q    <= cur_x_d;
      cur_y_q    <= cur_y_d;
      seq_busy_q <= seq_busy_d;
      seq_clr_q  <= seq_clr_d;
      seq_draw_q <= seq_draw_d;
      seq_row_q  <= seq_row_d;
      if (adv) begin
        p1_valid_q <= issue;
      end
      if (out_free) begin
        out_valid_q <= p1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    seq_idx_q <= seq_idx_d;
    seq_x_q   <= seq_x_d;
    seq_y_q   <= seq_y_d;
    if (adv) begin
      p1_meta_q <= p1_meta_d;
    end
    if (out_free) begin
      out_meta_q <= p1_meta_q;
      out_mask_q <= p1_meta_q.clr ? '0 : rdata_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_mask_q, out_meta_q.y, out_meta_q.x};
  assign m_axis_tuser  = out_meta_q.clr;
  assign m_axis_tlast  = out_meta_q.last;

endmodule
`default_nettype wire

/* src/tcgr_checker.sv */
// Port checker of the text console glyph renderer and its bind to the top level.
`default_nettype none
module tcgr_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               m_axis_tvalid,
  input wire logic                               m_axis_tready,
  input wire logic [31:0]                        m_axis_tdata,
  input wire logic [0:0]                         m_axis_tuser,
  input wire logic                               m_axis_tlast
);

  // A stalled output word stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  // A clear word carries no coordinate and no mask.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == 32'd0))
    else $error("clear word with non-zero payload");

  // The word after a non-final glyph row is the next row at the same x.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tuser[0] && !m_axis_tlast) ##1 m_axis_tvalid
    |-> (!m_axis_tuser[0] &&
         (m_axis_tdata[23:12] == $past(m_axis_tdata[23:12]) + 12'd1) &&
         (m_axis_tdata[11:0] == $past(m_axis_tdata[11:0]))))
    else $error("glyph rows out of sequence");

  // A clear word that is not final is followed by a glyph row at home.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tuser[0] && !m_axis_tlast) ##1 m_axis_tvalid
    |-> (!m_axis_tuser[0] && (m_axis_tdata[23:0] == 24'd0)))
    else $error("glyph after clear not drawn at home");

endmodule

bind text_console_glyph_renderer_core tcgr_checker u_tcgr_checker (.*);
`default_nettype wire

/* sim/text_console_glyph_renderer_core_test.sv */
// Self-checking testbench: random and directed console words against a cycle-free row predictor.
module text_console_glyph_renderer_core_test;
  import tcgr_pkg::*;

  localparam int unsigned LIMIT_CYCLES  = 200000;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned COORD_MASK    = (1 << COORD_BITS) - 1;

  typedef struct packed {
    logic                  clr;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [PAT_BITS-1:0]   mask;
    logic                  last;
  } glyph_row_t;

  class raster_tracker;
    bit [PAT_BITS-1:0] font [FONT_CHARS_DEF * GLYPH_ROWS];
    int unsigned       cur_x;
    int unsigned       cur_y;
    int unsigned       scr_w;
    int unsigned       scr_h;
    glyph_row_t        pending_rows [$];
    int unsigned       failures;
    int unsigned       reported;

    function new();
      cur_x    = 0;
      cur_y    = 0;
      scr_w    = WIDTH_RESET;
      scr_h    = HEIGHT_RESET;
      failures = 0;
      reported = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [DIM_BITS-1:0] value);
      if (idx == REG_SCREEN_WIDTH) begin
        scr_w = value;
      end else if (idx == REG_SCREEN_HEIGHT) begin
        scr_h = value;
      end
    endfunction

    function void push_clear(logic last);
      glyph_row_t want;
      cur_x = 0;
      cur_y = 0;
      want = '0;
      want.clr = 1'b1;
      want.last = last;
      pending_rows.push_back(want);
    endfunction

    function void render_glyph(logic [CODE_BITS-1:0] code);
      glyph_row_t want;
      if (cur_x + GLYPH_ROWS > scr_w) begin
        cur_x = 0;
        cur_y = (cur_y + GLYPH_ROWS) & COORD_MASK;
      end
      if (cur_y + GLYPH_ROWS > scr_h) begin
        push_clear(1'b0);
      end
      for (int unsigned r = 0; r < GLYPH_ROWS; r++) begin
        want.clr  = 1'b0;
        want.x    = COORD_BITS'(cur_x);
        want.y    = COORD_BITS'((cur_y + r) & COORD_MASK);
        want.mask = font[code * GLYPH_ROWS + r];
        want.last = (r == GLYPH_ROWS - 1);
        pending_rows.push_back(want);
      end
      cur_x = (cur_x + GLYPH_ROWS) & COORD_MASK;
    endfunction

    function void note_word(mode_e mode_sel, logic [CODE_BITS-1:0] code,
                            logic [ROW_BITS-1:0] row, logic [PAT_BITS-1:0] pat,
                            logic [DIGIT_BITS-1:0] digit);
      case (mode_sel)
        MODE_LOAD: begin
          font[code * GLYPH_ROWS + row] = pat;
        end
        MODE_CLEAR: begin
          push_clear(1'b1);
        end
        MODE_CHAR: begin
          if (code == CHAR_NEWLINE) begin
            cur_x = 0;
            cur_y = (cur_y + GLYPH_ROWS) & COORD_MASK;
            if (cur_y + GLYPH_ROWS > scr_h) begin
              push_clear(1'b1);
            end
          end else begin
            render_glyph(code);
          end
        end
        default: begin
          if (digit > DIGIT_MAX) begin
            render_glyph(ASCII_HEX_A + CODE_BITS'(digit));
          end else begin
            render_glyph(ASCII_ZERO + CODE_BITS'(digit));
          end
        end
      endcase
    endfunction

    function void check_row(glyph_row_t got);
      glyph_row_t want;
      if (pending_rows.size() == 0) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("Unexpected output word: clr=%0d x=%0d y=%0d mask=%02h last=%0d",
                   got.clr, got.x, got.y, got.mask, got.last);
        end
        return;
      end
      want = pending_rows.pop_front();
      if (got !== want) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("Mismatch: expected clr=%0d x=%0d y=%0d mask=%02h last=%0d",
                   want.clr, want.x, want.y, want.mask, want.last);
          $display("          got      clr=%0d x=%0d y=%0d mask=%02h last=%0d",
                   got.clr, got.x, got.y, got.mask, got.last);
        end
      end
    endfunction
  endclass

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [23:0]             s_axis_tdata  = '0;
  logic [1:0]              s_axis_tuser  = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [31:0]             m_axis_tdata;
  logic [0:0]              m_axis_tuser;
  logic                    m_axis_tlast;
  logic                    cfg_valid_i   = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i   = '0;
  logic [DIM_BITS-1:0]     cfg_data_i    = '0;

  raster_tracker     tracker = new();
  bit                steady  = 1'b0;
  int unsigned       cycle_count = 0;
  bit [GLYPH_ROWS-1:0] rows_loaded [FONT_CHARS_DEF];
  int unsigned       drawable [$];

  text_console_glyph_renderer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_row({m_axis_tuser[0], m_axis_tdata[11:0], m_axis_tdata[23:12],
                         m_axis_tdata[31:24], m_axis_tlast});
    end
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 12);
  end

  task automatic push_item(mode_e mode_sel, logic [CODE_BITS-1:0] code,
                           logic [ROW_BITS-1:0] row, logic [PAT_BITS-1:0] pat,
                           logic [DIGIT_BITS-1:0] digit);
    while (!steady && $urandom_range(0, 99) < 12) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode_sel;
    s_axis_tdata  <= {2'b00, digit, pat, row, code};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_word(mode_sel, code, row, pat, digit);
  endtask

  task automatic send_op(mode_e mode_sel, logic [CODE_BITS-1:0] code,
                         logic [DIGIT_BITS-1:0] digit);
    push_item(mode_sel, code, ROW_BITS'($urandom), PAT_BITS'($urandom), digit);
  endtask

  task automatic load_row(logic [CODE_BITS-1:0] code, logic [ROW_BITS-1:0] row,
                          logic [PAT_BITS-1:0] pat);
    push_item(MODE_LOAD, code, row, pat, DIGIT_BITS'($urandom));
    if (rows_loaded[code] != '1) begin
      rows_loaded[code][row] = 1'b1;
      if (rows_loaded[code] == '1 && code != CHAR_NEWLINE) begin
        drawable.push_back(code);
      end
    end
  endtask

  task automatic program_screen(logic [DIM_BITS-1:0] w, logic [DIM_BITS-1:0] h);
    s_axis_tvalid <= 1'b0;
    while (tracker.pending_rows.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    for (int i = 0; i < 2; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= (i == 0) ? REG_SCREEN_WIDTH : REG_SCREEN_HEIGHT;
      cfg_data_i  <= (i == 0) ? w : h;
      do @(posedge clk_i); while (!cfg_ready_o);
      tracker.set_reg((i == 0) ? REG_SCREEN_WIDTH : REG_SCREEN_HEIGHT, (i == 0) ? w : h);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(int unsigned count);
    int unsigned            pick;
    logic [CODE_BITS-1:0]   code;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        if ($urandom_range(0, 1) == 1) begin
          code = CODE_BITS'(drawable[$urandom_range(0, drawable.size() - 1)]);
        end else begin
          code = CODE_BITS'($urandom);
        end
        load_row(code, ROW_BITS'($urandom), PAT_BITS'($urandom));
      end else if (pick < 55) begin
        code = CODE_BITS'(drawable[$urandom_range(0, drawable.size() - 1)]);
        send_op(MODE_CHAR, code, DIGIT_BITS'($urandom));
      end else if (pick < 80) begin
        send_op(MODE_HEX, CODE_BITS'($urandom), DIGIT_BITS'($urandom));
      end else if (pick < 94) begin
        send_op(MODE_CHAR, CHAR_NEWLINE, DIGIT_BITS'($urandom));
      end else begin
        send_op(MODE_CLEAR, CODE_BITS'($urandom), DIGIT_BITS'($urandom));
      end
    end
  endtask

  initial begin
    logic [PAT_BITS-1:0] pat;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the glyphs used by the directed words; every hex glyph is kept drawable.
    for (int c = 0; c < FONT_CHARS_DEF; c++) begin
      if (c inside {0, 32, 35, 97, 127, [48:57], [65:70]}) begin
        for (int r = 0; r < GLYPH_ROWS; r++) begin
          if (c == 127) begin
            pat = 8'hFF;
          end else if (c == 0 && r == 0) begin
            pat = 8'h00;
          end else if (c == 0 && r == GLYPH_ROWS - 1) begin
            pat = 8'hFF;
          end else begin
            pat = PAT_BITS'($urandom);
          end
          load_row(CODE_BITS'(c), ROW_BITS'(r), pat);
        end
      end
    end

    send_op(MODE_CLEAR, CODE_BITS'($urandom), DIGIT_BITS'($urandom));
    send_op(MODE_CHAR, 7'd0, DIGIT_BITS'($urandom));
    send_op(MODE_CHAR, 7'd127, DIGIT_BITS'($urandom));
    send_op(MODE_HEX, CODE_BITS'($urandom), 4'd0);
    send_op(MODE_HEX, CODE_BITS'($urandom), 4'd9);
    send_op(MODE_HEX, CODE_BITS'($urandom), 4'd10);
    send_op(MODE_HEX, CODE_BITS'($urandom), 4'd15);
    send_op(MODE_CHAR, CHAR_NEWLINE, DIGIT_BITS'($urandom));
    send_op(MODE_CHAR, 7'd97, DIGIT_BITS'($urandom));
    load_row(7'd127, 3'd7, 8'h00);
    send_op(MODE_CHAR, 7'd127, DIGIT_BITS'($urandom));

    // Two glyphs per line and two lines: the fifth glyph wraps past the bottom.
    program_screen(12'd16, 12'd16);
    send_op(MODE_CLEAR, CODE_BITS'($urandom), DIGIT_BITS'($urandom));
    send_op(MODE_CHAR, 7'd65, DIGIT_BITS'($urandom));
    send_op(MODE_CHAR, 7'd66, DIGIT_BITS'($urandom));
    send_op(MODE_CHAR, 7'd67, DIGIT_BITS'($urandom));
    send_op(MODE_CHAR, 7'd68, DIGIT_BITS'($urandom));
    send_op(MODE_CHAR, 7'd69, DIGIT_BITS'($urandom));
    send_op(MODE_CHAR, CHAR_NEWLINE, DIGIT_BITS'($urandom));
    send_op(MODE_CHAR, CHAR_NEWLINE, DIGIT_BITS'($urandom));

    // A screen smaller than one glyph still gets the glyph drawn at home.
    program_screen(12'd5, 12'd7);
    send_op(MODE_HEX, CODE_BITS'($urandom), 4'd3);
    send_op(MODE_CHAR, CHAR_NEWLINE, DIGIT_BITS'($urandom));

    program_screen(12'd4095, 12'd4095);
    send_op(MODE_CHAR, 7'd35, DIGIT_BITS'($urandom));
    send_op(MODE_HEX, CODE_BITS'($urandom), 4'd12);

    program_screen(WIDTH_RESET, HEIGHT_RESET);
    steady = 1'b1;
    random_phase(40);
    program_screen(12'd8, 12'd8);
    steady = 1'b0;
    random_phase(24);
    program_screen(12'd4095, 12'd8);
    random_phase(16);
    program_screen(12'd8, 12'd4095);
    random_phase(16);
    program_screen(DIM_BITS'($urandom_range(8, 96)), DIM_BITS'($urandom_range(8, 96)));
    random_phase(16);
    program_screen(DIM_BITS'($urandom_range(8, 4095)), DIM_BITS'($urandom_range(8, 4095)));
    random_phase(16);

    s_axis_tvalid <= 1'b0;
    while (tracker.pending_rows.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tracker.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
